// ===== rtl/core/pixel_format_converter_core_defines.svh =====
// Assertion macros for the converter core.
`ifndef PIXEL_FORMAT_CONVERTER_CORE_DEFINES_SVH
`define PIXEL_FORMAT_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pfc_pkg.sv =====
package pfc_pkg;

    // Framebuffer formats
    localparam logic [2:0] FMT_RGB565   = 3'd0;
    localparam logic [2:0] FMT_ARGB4444 = 3'd1;
    localparam logic [2:0] FMT_ARGB8888 = 3'd2;
    localparam logic [2:0] FMT_ARGB1555 = 3'd3;
    localparam logic [2:0] FMT_YUV422   = 3'd4;
    localparam logic [2:0] FMT_I8       = 3'd5;
    localparam logic [2:0] FMT_I4       = 3'd6;
    localparam logic [2:0] FMT_I2       = 3'd7;

    // Operations
    localparam logic [1:0] OP_PACK      = 2'd0;
    localparam logic [1:0] OP_UNPACK    = 2'd1;
    localparam logic [1:0] OP_PAL_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd0;
    localparam logic [1:0] REG_PALETTE_FIRST = 2'd1;
    localparam logic [1:0] REG_PALETTE_COUNT = 2'd2;

    localparam int unsigned CFG_DATA_W = 9;

    // Pixels per packed value
    localparam logic [2:0] PPV_ONE  = 3'd1;
    localparam logic [2:0] PPV_TWO  = 3'd2;
    localparam logic [2:0] PPV_FOUR = 3'd4;

    localparam logic [2:0] FORMAT_RESET        = FMT_ARGB8888;
    localparam logic [8:0] PALETTE_FIRST_RESET = 9'd0;
    localparam logic [8:0] PALETTE_COUNT_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] pixel_in;
        logic [7:0]  entry_index;
        logic [7:0]  entry_red;
        logic [7:0]  entry_green;
        logic [7:0]  entry_blue;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [2:0]  pixels_per_value;
        logic        unsupported;
    } out_beat_t;

    typedef struct packed {
        logic [2:0] pixel_format;
        logic [8:0] palette_first;
        logic [8:0] palette_count;
    } cfg_t;

endpackage

// ===== rtl/core/pfc_palette.sv =====
module pfc_palette
    import pfc_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 256,
    parameter int unsigned IDX_W         = $clog2(PALETTE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [23:0]      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [23:0]      rd_data
);

    logic [23:0]              mem [PALETTE_DEPTH];
    logic [23:0]              mem_rd_reg;
    logic [PALETTE_DEPTH-1:0] written_reg;
    logic                     rd_written_reg;
    logic [IDX_W-1:0]         rd_addr_reg;
    logic [7:0]               grey;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg  <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Entries never written read as the grey ramp that reset leaves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign grey    = 8'(rd_addr_reg);
    assign rd_data = rd_written_reg ? mem_rd_reg : {grey, grey, grey};

endmodule

// ===== rtl/core/pfc_convert.sv =====
module pfc_convert
    import pfc_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 256
)
(
    input  cfg_t        cfg,
    input  in_beat_t    beat,
    input  logic [23:0] pal_data,
    output out_beat_t   result
);

    logic [31:0] s;
    logic        in_window;

    assign s = beat.pixel_in;

    assign in_window = (s >= {23'd0, cfg.palette_first})
                    && (s <  {23'd0, cfg.palette_count})
                    && (s <  32'(PALETTE_DEPTH));

    always_comb
    begin
        result.pixel_out        = '0;
        result.pixels_per_value = PPV_ONE;
        result.unsupported      = 1'b0;
        unique case (beat.operation)
            OP_PACK:
            begin
                unique case (cfg.pixel_format)
                    FMT_RGB565:
                        result.pixel_out = {16'd0, s[23:19], s[15:10], s[7:3]};
                    FMT_ARGB4444:
                        result.pixel_out = {16'd0, s[31:28], s[23:20], s[15:12], s[7:4]};
                    FMT_ARGB8888:
                        result.pixel_out = s;
                    FMT_ARGB1555:
                        result.pixel_out = {16'd0, s[31], s[23:19], s[15:11], s[7:3]};
                    FMT_YUV422:
                    begin
                        result.pixel_out        = {s[7:0], s[31:24], s[23:16], s[31:24]};
                        result.pixels_per_value = PPV_TWO;
                    end
                    FMT_I8:
                        result.pixel_out = {24'd0, s[7:0]};
                    FMT_I4:
                    begin
                        result.pixel_out        = {28'd0, s[3:0]};
                        result.pixels_per_value = PPV_TWO;
                    end
                    FMT_I2:
                    begin
                        result.pixel_out        = {30'd0, s[1:0]};
                        result.pixels_per_value = PPV_FOUR;
                    end
                    default:
                        result.pixel_out = '0;
                endcase
            end
            OP_UNPACK:
            begin
                unique case (cfg.pixel_format)
                    FMT_RGB565:
                        result.pixel_out = {8'd0, s[15:11], s[15:13], s[10:5], s[10:9],
                                            s[4:0], s[4:2]};
                    FMT_ARGB4444:
                        result.pixel_out = {8'd0, s[11:8], s[11:8], s[7:4], s[7:4],
                                            s[3:0], s[3:0]};
                    FMT_ARGB8888:
                        result.pixel_out = s;
                    FMT_ARGB1555:
                        result.pixel_out = {8'd0, s[14:10], s[14:12], s[9:5], s[9:7],
                                            s[4:0], s[4:2]};
                    FMT_I8:
                    begin
                        if (in_window)
                        begin
                            result.pixel_out = {8'd0, pal_data};
                        end
                        else
                        begin
                            result.unsupported = 1'b1;
                        end
                    end
                    FMT_YUV422, FMT_I4, FMT_I2:
                        result.unsupported = 1'b1;
                    default:
                        result.unsupported = 1'b1;
                endcase
            end
            OP_PAL_WRITE:
                result.unsupported = 1'b0;
            default:
                result.unsupported = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/pixel_format_converter_core.sv =====
// Pixel converter between ARGB8888 and one configured framebuffer format. It takes one beat
// per clock and returns one result beat for each, through the stage-one beat register and
// the output register; the input stalls only while both stages hold a beat and the output
// is stalled. The palette is a simple dual-port memory, written and read at the edge that
// accepts a beat; the read data is registered and the conversion runs between that register
// and the output register. Per-entry written bits make never-written entries read as the
// grey ramp, so no clearing pass is needed after reset. A palette write followed directly by
// a read of the same entry sees the new value. Configuration registers take effect at once,
// so they must be written only while no beat is in flight.
`include "pixel_format_converter_core_defines.svh"

module pixel_format_converter_core
    import pfc_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

    cfg_t        cfg_reg;
    in_beat_t    s1_beat_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_beat_t   out_data_reg;
    out_beat_t   conv_result;
    logic        in_accept;
    logic        out_load;
    logic        pal_wr_en;
    logic [23:0] pal_rd_data;

    assign out_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    assign pal_wr_en = in_accept && (in_data.operation == OP_PAL_WRITE)
                    && ({24'd0, in_data.entry_index} < 32'(PALETTE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format  <= FORMAT_RESET;
            cfg_reg.palette_first <= PALETTE_FIRST_RESET;
            cfg_reg.palette_count <= PALETTE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT:  cfg_reg.pixel_format  <= cfg_wdata[2:0];
                REG_PALETTE_FIRST: cfg_reg.palette_first <= cfg_wdata;
                REG_PALETTE_COUNT: cfg_reg.palette_count <= cfg_wdata;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_beat_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg <= conv_result;
        end
    end

    pfc_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .IDX_W         (IDX_W)
    ) u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (pal_wr_en),
        .wr_addr (in_data.entry_index[IDX_W-1:0]),
        .wr_data ({in_data.entry_red, in_data.entry_green, in_data.entry_blue}),
        .rd_en   (in_accept),
        .rd_addr (in_data.pixel_in[IDX_W-1:0]),
        .rd_data (pal_rd_data)
    );

    pfc_convert #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_convert (
        .cfg      (cfg_reg),
        .beat     (s1_beat_reg),
        .pal_data (pal_rd_data),
        .result   (conv_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `PFC_ASSERT_NOW(a_full_pipe_stalls, s1_valid_reg && out_valid_reg && out_stall,
        in_stall, "input taken while both stages are held")
    `PFC_ASSERT_NEXT(a_accept_fills_stage, in_accept,
        s1_valid_reg && out_valid_reg == $past(out_valid_next), "accepted beat lost")
    `PFC_ASSERT_NEXT(a_write_result_zero, out_load && s1_beat_reg.operation == OP_PAL_WRITE,
        out_data_reg.pixel_out == '0 && !out_data_reg.unsupported, "palette write result")
    `PFC_ASSERT_NEXT(a_ppv_one_off_pack, out_load && s1_beat_reg.operation != OP_PACK,
        out_data_reg.pixels_per_value == PPV_ONE, "pixels per value not one outside pack")

endmodule
